// ===== src/debounced_setpoint_adjuster_top_assert.svh =====
// Assertion macros shared by the setpoint adjuster checkers.
`ifndef DEBOUNCED_SETPOINT_ADJUSTER_TOP_ASSERT_SVH
`define DEBOUNCED_SETPOINT_ADJUSTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/dsa_pkg.sv =====
// Types and constants shared by the setpoint adjuster modules.
package dsa_pkg;

	localparam int unsigned VAL_W      = 10;
	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 32;

	typedef logic [VAL_W-1:0]      dsa_val_t;
	typedef logic [1:0]            dsa_reg_idx_t;
	typedef logic [APB_DATA_W-1:0] dsa_apb_data_t;

	// Register indexes, each at byte address 4 * index.
	localparam dsa_reg_idx_t REG_DEBOUNCE_TICKS  = 2'd0;
	localparam dsa_reg_idx_t REG_SETPOINT_MIN    = 2'd1;
	localparam dsa_reg_idx_t REG_SETPOINT_MAX    = 2'd2;
	localparam dsa_reg_idx_t REG_ALARM_THRESHOLD = 2'd3;

	// Register values after reset.
	localparam dsa_val_t DEBOUNCE_TICKS_RST  = 10'd30;
	localparam dsa_val_t SETPOINT_MIN_RST    = 10'd0;
	localparam dsa_val_t SETPOINT_MAX_RST    = 10'd600;
	localparam dsa_val_t ALARM_THRESHOLD_RST = 10'd550;

	// Quiet-tick counters saturate here.
	localparam dsa_val_t QUIET_MAX = '1;

	typedef struct packed {
		dsa_val_t debounce_ticks;
		dsa_val_t setpoint_min;
		dsa_val_t setpoint_max;
		dsa_val_t alarm_threshold;
	} dsa_cfg_t;

	typedef struct packed {
		logic up_key_raw;
		logic down_key_raw;
		logic enc_a_edge;
		logic enc_a_level;
		logic enc_b_level;
	} dsa_tick_t;

endpackage

// ===== src/dsa_if.sv =====
// Valid/ready channel interfaces for tick items and setpoint results.
interface dsa_tick_if;
	logic valid;
	logic ready;
	logic up_key_raw;
	logic down_key_raw;
	logic enc_a_edge;
	logic enc_a_level;
	logic enc_b_level;

	modport source (
		output valid, up_key_raw, down_key_raw, enc_a_edge, enc_a_level, enc_b_level,
		input  ready
	);
	modport sink (
		input  valid, up_key_raw, down_key_raw, enc_a_edge, enc_a_level, enc_b_level,
		output ready
	);
endinterface

interface dsa_result_if;
	logic              valid;
	logic              ready;
	dsa_pkg::dsa_val_t setpoint_value;
	logic              alarm;

	modport source (
		output valid, setpoint_value, alarm,
		input  ready
	);
	modport sink (
		input  valid, setpoint_value, alarm,
		output ready
	);
endinterface

// ===== src/debounced_setpoint_adjuster_top.sv =====
// Top level of the debounced setpoint adjuster.
//
// Usage: every transfer on the tick channel is one 1 ms sample of the up and
// down keys (active low) and of the rotary encoder. Every tick gives exactly
// one transfer on the result channel with the new setpoint and the alarm flag.
// Registers (debounce length, setpoint range, alarm threshold) must be written
// over the APB port while no tick is in flight; the block does not enforce it.
// Timing: a tick is held in an input register; the encoder step, both
// debouncers and the clamped up/down steps are worked out from it and
// written to the result register once that register is free. One tick
// per cycle is taken when the receiver keeps up; the three chained clamp
// adders between the two registers set the clock.
// Reset clears both valid flags, sets the keys to released with zero quiet
// counts, the setpoint to zero and the registers to their defaults.
// When the receiver stalls, the result register holds its value and one more
// tick can still be taken into the input register; after that tick ready
// drops until the result is taken.
module debounced_setpoint_adjuster_top #(
	parameter int unsigned STEP_SIZE = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	dsa_tick_if.sink                       tick,
	dsa_result_if.source                   result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dsa_pkg::APB_ADDR_W-1:0] paddr,
	input  dsa_pkg::dsa_apb_data_t         pwdata,
	output dsa_pkg::dsa_apb_data_t         prdata,
	output logic                           pready
);
	import dsa_pkg::*;

	dsa_cfg_t  cfg;
	dsa_tick_t tick_s1;
	logic      valid_s1;
	logic      valid_s2;
	dsa_val_t  setpoint_s2;
	logic      alarm_s2;
	dsa_val_t  setpoint_q;
	logic      advance;
	logic      tick_take;
	logic      enc_step;
	logic      up_press;
	logic      down_press;
	dsa_val_t  sp_enc;
	dsa_val_t  sp_up;
	dsa_val_t  sp_down;

	dsa_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake: the input stage moves on when the result register is free.
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign tick.ready = !valid_s1 || advance;
	assign tick_take  = tick.valid && tick.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_take) begin
			tick_s1.up_key_raw   <= tick.up_key_raw;
			tick_s1.down_key_raw <= tick.down_key_raw;
			tick_s1.enc_a_edge   <= tick.enc_a_edge;
			tick_s1.enc_a_level  <= tick.enc_a_level;
			tick_s1.enc_b_level  <= tick.enc_b_level;
		end
	end

	// Key debouncers; their state moves only when a tick is processed.
	dsa_debounce u_up_key (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (advance),
		.raw            (tick_s1.up_key_raw),
		.debounce_ticks (cfg.debounce_ticks),
		.press          (up_press)
	);

	dsa_debounce u_down_key (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (advance),
		.raw            (tick_s1.down_key_raw),
		.debounce_ticks (cfg.debounce_ticks),
		.press          (down_press)
	);

	// Encoder step on an A edge with A low; B gives the direction.
	assign enc_step = tick_s1.enc_a_edge && !tick_s1.enc_a_level;

	// Steps in tick order: encoder, up key, down key.
	dsa_step #(.StepSize(STEP_SIZE)) u_step_enc (
		.cur     (setpoint_q),
		.step_en (enc_step),
		.up      (tick_s1.enc_b_level),
		.lo      (cfg.setpoint_min),
		.hi      (cfg.setpoint_max),
		.nxt     (sp_enc)
	);

	dsa_step #(.StepSize(STEP_SIZE)) u_step_up (
		.cur     (sp_enc),
		.step_en (up_press),
		.up      (1'b1),
		.lo      (cfg.setpoint_min),
		.hi      (cfg.setpoint_max),
		.nxt     (sp_up)
	);

	dsa_step #(.StepSize(STEP_SIZE)) u_step_down (
		.cur     (sp_up),
		.step_en (down_press),
		.up      (1'b0),
		.lo      (cfg.setpoint_min),
		.hi      (cfg.setpoint_max),
		.nxt     (sp_down)
	);

	// Setpoint state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= '0;
		end else if (advance) begin
			setpoint_q <= sp_down;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			setpoint_s2 <= sp_down;
			alarm_s2    <= sp_down > cfg.alarm_threshold;
		end
	end

	assign result.valid          = valid_s2;
	assign result.setpoint_value = setpoint_s2;
	assign result.alarm          = alarm_s2;

endmodule

// ===== src/dsa_apb_regs.sv =====
// APB configuration registers of the setpoint adjuster.
module dsa_apb_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [dsa_pkg::APB_ADDR_W-1:0]      paddr,
	input  dsa_pkg::dsa_apb_data_t              pwdata,
	output dsa_pkg::dsa_apb_data_t              prdata,
	output logic                                pready,
	output dsa_pkg::dsa_cfg_t                   cfg
);
	import dsa_pkg::*;

	dsa_cfg_t     cfg_q;
	dsa_reg_idx_t reg_idx;
	logic         wr_en;
	dsa_val_t     rd_val;

	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	// Register write on the access phase of an APB transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks  <= DEBOUNCE_TICKS_RST;
			cfg_q.setpoint_min    <= SETPOINT_MIN_RST;
			cfg_q.setpoint_max    <= SETPOINT_MAX_RST;
			cfg_q.alarm_threshold <= ALARM_THRESHOLD_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_DEBOUNCE_TICKS:  cfg_q.debounce_ticks  <= pwdata[VAL_W-1:0];
				REG_SETPOINT_MIN:    cfg_q.setpoint_min    <= pwdata[VAL_W-1:0];
				REG_SETPOINT_MAX:    cfg_q.setpoint_max    <= pwdata[VAL_W-1:0];
				REG_ALARM_THRESHOLD: cfg_q.alarm_threshold <= pwdata[VAL_W-1:0];
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		unique case (reg_idx)
			REG_DEBOUNCE_TICKS:  rd_val = cfg_q.debounce_ticks;
			REG_SETPOINT_MIN:    rd_val = cfg_q.setpoint_min;
			REG_SETPOINT_MAX:    rd_val = cfg_q.setpoint_max;
			REG_ALARM_THRESHOLD: rd_val = cfg_q.alarm_threshold;
			default:             rd_val = '0;
		endcase
	end

	assign prdata = {{(APB_DATA_W-VAL_W){1'b0}}, rd_val};

endmodule

// ===== src/dsa_debounce.sv =====
// Key debouncer: last raw level, stable level and a saturating quiet-tick count.
module dsa_debounce (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              raw,
	input  dsa_pkg::dsa_val_t debounce_ticks,
	output logic              press
);
	import dsa_pkg::*;

	logic     last_raw_q;
	logic     stable_q;
	dsa_val_t quiet_q;
	dsa_val_t quiet_d;
	logic     take_level;

	// A raw change restarts the count; otherwise it counts up and saturates.
	always_comb begin
		if (raw != last_raw_q) begin
			quiet_d = '0;
		end else if (quiet_q != QUIET_MAX) begin
			quiet_d = quiet_q + 1'b1;
		end else begin
			quiet_d = quiet_q;
		end
	end

	// The stable level follows once the raw level has been quiet long enough.
	assign take_level = (quiet_d >= debounce_ticks) && (raw != stable_q);
	assign press      = take_level && !raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q <= 1'b1;
			stable_q   <= 1'b1;
			quiet_q    <= '0;
		end else if (en) begin
			last_raw_q <= raw;
			quiet_q    <= quiet_d;
			if (take_level) begin
				stable_q <= raw;
			end
		end
	end

endmodule

// ===== src/dsa_step.sv =====
// One setpoint step of a fixed size, clamped to the configured range.
module dsa_step #(
	parameter int unsigned StepSize = 1
) (
	input  dsa_pkg::dsa_val_t cur,
	input  logic              step_en,
	input  logic              up,
	input  dsa_pkg::dsa_val_t lo,
	input  dsa_pkg::dsa_val_t hi,
	output dsa_pkg::dsa_val_t nxt
);
	import dsa_pkg::*;

	// Signed width that holds the full setpoint range plus or minus one step.
	localparam int unsigned SumW = $clog2((2 ** VAL_W) + StepSize) + 1;

	logic signed [SumW-1:0] cur_x;
	logic signed [SumW-1:0] step_x;
	logic signed [SumW-1:0] sum_x;
	logic signed [SumW-1:0] lo_x;
	logic signed [SumW-1:0] hi_x;

	assign cur_x  = signed'({{(SumW-VAL_W){1'b0}}, cur});
	assign lo_x   = signed'({{(SumW-VAL_W){1'b0}}, lo});
	assign hi_x   = signed'({{(SumW-VAL_W){1'b0}}, hi});
	assign step_x = signed'(SumW'(StepSize));
	assign sum_x  = up ? (cur_x + step_x) : (cur_x - step_x);

	// A step below the lower bound gets the lower bound, even when the range is inverted.
	always_comb begin
		priority if (!step_en) begin
			nxt = cur;
		end else if (sum_x < lo_x) begin
			nxt = lo;
		end else if (sum_x > hi_x) begin
			nxt = hi;
		end else begin
			nxt = sum_x[VAL_W-1:0];
		end
	end

endmodule

// ===== src/dsa_checker.sv =====
// Port-level checker for the setpoint adjuster and its bind to the top level.
`include "debounced_setpoint_adjuster_top_assert.svh"

module dsa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              tick_valid,
	input logic              tick_ready,
	input logic              result_valid,
	input logic              result_ready,
	input dsa_pkg::dsa_val_t setpoint_value,
	input logic              alarm
);
	import dsa_pkg::*;

	// A stalled result holds its payload.
	`DSA_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(setpoint_value) && $stable(alarm), "stalled result changed")

	// The input side only stalls when a result is waiting.
	`DSA_ASSERT_SAME(a_ready_stall, clk, arst_n, !tick_ready, result_valid, "tick stalled without a pending result")

	// A new result follows a tick transfer through the input register.
	`DSA_ASSERT_SAME(a_result_cause, clk, arst_n, $rose(result_valid), $past(tick_valid && tick_ready, 2), "result without a tick transfer")

	// The alarm needs a setpoint above some threshold, so never at zero.
	`DSA_ASSERT_SAME(a_alarm_nonzero, clk, arst_n, result_valid && alarm, setpoint_value != '0, "alarm with zero setpoint")

endmodule

bind debounced_setpoint_adjuster_top dsa_checker u_dsa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.tick_valid     (tick.valid),
	.tick_ready     (tick.ready),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.setpoint_value (result.setpoint_value),
	.alarm          (result.alarm)
);

// ===== verif/tb_debounced_setpoint_adjuster_top.sv =====
// Self-checking testbench for the debounced setpoint adjuster top level.
`timescale 1ns / 1ps

module tb_debounced_setpoint_adjuster_top;
	import dsa_pkg::*;

	localparam int          STEP        = 1;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_PAD   = 3;
	localparam int unsigned RANDOM_TICKS = 1950;
	localparam int unsigned LONG_HOLD_TICKS = 1040;
	localparam int          KEY_UP      = 0;
	localparam int          KEY_DOWN    = 1;

	typedef struct packed {
		dsa_val_t setpoint_value;
		logic     alarm;
	} setpoint_result_t;

	// One row of the directed table: a register write or a tick, the latter
	// optionally with a hand-written result.
	typedef struct {
		bit               is_cfg;
		dsa_reg_idx_t     idx;
		dsa_val_t         val;
		dsa_tick_t        tick;
		bit               typed;
		setpoint_result_t want;
	} directed_row_t;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           psel;
	logic           penable;
	logic           pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	dsa_apb_data_t  pwdata;
	dsa_apb_data_t  prdata;
	logic           pready;

	dsa_tick_if   tick_ch ();
	dsa_result_if result_ch ();

	debounced_setpoint_adjuster_top #(
		.STEP_SIZE(STEP)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow of the block: registers, key debouncers and setpoint.
	dsa_cfg_t cfg_model;
	dsa_val_t setpoint_model;
	logic     key_last[2];
	logic     key_stable[2];
	dsa_val_t key_quiet[2];

	setpoint_result_t pending_setpoints[$];
	int unsigned      mismatch_count = 0;
	int unsigned      cycle_count = 0;
	bit               steady = 1'b0;

	// Random key generator: intended level and ticks left at that level.
	logic        key_level[2];
	int unsigned key_hold[2];
	int unsigned hold_span = 8;

	directed_row_t directed_rows[$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("debounced_setpoint_adjuster_top: mismatch");
			$finish;
		end
	end

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s: expected %0d, got %0d", what, want, got);
	endtask

	// One clamped step of the setpoint, up or down.
	function automatic dsa_val_t clamp_step(input dsa_val_t cur, input bit up);
		int next;
		next = int'(cur) + (up ? STEP : -STEP);
		if (next < int'(cfg_model.setpoint_min))
			next = int'(cfg_model.setpoint_min);
		else if (next > int'(cfg_model.setpoint_max))
			next = int'(cfg_model.setpoint_max);
		return dsa_val_t'(next);
	endfunction

	// Quiet count update, then acceptance of a new level; a press steps.
	function automatic void debounce_key(input int k, input logic raw);
		if (raw != key_last[k]) begin
			key_last[k] = raw;
			key_quiet[k] = '0;
		end else if (key_quiet[k] != QUIET_MAX) begin
			key_quiet[k] = key_quiet[k] + 1'b1;
		end
		if (key_quiet[k] >= cfg_model.debounce_ticks && raw != key_stable[k]) begin
			key_stable[k] = raw;
			if (raw == 1'b0)
				setpoint_model = clamp_step(setpoint_model, k == KEY_UP);
		end
	endfunction

	// Setpoint after one tick: encoder first, then up key, then down key.
	function automatic setpoint_result_t advance_setpoint(input dsa_tick_t t);
		setpoint_result_t r;
		if (t.enc_a_edge && !t.enc_a_level)
			setpoint_model = clamp_step(setpoint_model, t.enc_b_level);
		debounce_key(KEY_UP, t.up_key_raw);
		debounce_key(KEY_DOWN, t.down_key_raw);
		r.setpoint_value = setpoint_model;
		r.alarm = setpoint_model > cfg_model.alarm_threshold;
		return r;
	endfunction

	// Mostly held key levels long enough to pass the debouncer, with bounce,
	// random encoder activity and a little pure noise; with long_hold the up key is held pressed.
	function automatic dsa_tick_t next_random_tick(input bit long_hold);
		dsa_tick_t t;
		logic      raw[2];
		for (int k = 0; k < 2; k++) begin
			if (key_hold[k] == 0) begin
				key_level[k] = ~key_level[k];
				key_hold[k] = $urandom_range(1, hold_span);
			end
			key_hold[k]--;
			raw[k] = key_level[k];
			if ($urandom_range(0, 9) == 0)
				raw[k] = ~raw[k];
		end
		t.up_key_raw   = raw[KEY_UP];
		t.down_key_raw = raw[KEY_DOWN];
		t.enc_a_edge   = $urandom_range(0, 2) == 0;
		t.enc_a_level  = 1'($urandom_range(0, 1));
		t.enc_b_level  = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 19) == 0)
			t = dsa_tick_t'(5'($urandom()));
		if (long_hold)
			t.up_key_raw = 1'b0;
		return t;
	endfunction

	// One APB transfer, started and finished on a rising edge.
	task automatic apb_transfer(input bit wr, input dsa_reg_idx_t idx,
			input dsa_apb_data_t wdata, output dsa_apb_data_t rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Register write with random upper bits, which the block must drop.
	task automatic write_reg(input dsa_reg_idx_t idx, input dsa_val_t val);
		dsa_apb_data_t wdata;
		dsa_apb_data_t unused;
		wdata = $urandom();
		wdata[VAL_W-1:0] = val;
		apb_transfer(1'b1, idx, wdata, unused);
		case (idx)
			REG_DEBOUNCE_TICKS:  cfg_model.debounce_ticks  = val;
			REG_SETPOINT_MIN:    cfg_model.setpoint_min    = val;
			REG_SETPOINT_MAX:    cfg_model.setpoint_max    = val;
			REG_ALARM_THRESHOLD: cfg_model.alarm_threshold = val;
			default: ;
		endcase
	endtask

	// Read back every register and compare with the shadow copy.
	task automatic check_regs();
		dsa_reg_idx_t  idx;
		dsa_apb_data_t rdata;
		dsa_val_t      want;
		for (int i = 0; i < 4; i++) begin
			idx = dsa_reg_idx_t'(i);
			apb_transfer(1'b0, idx, '0, rdata);
			case (idx)
				REG_DEBOUNCE_TICKS:  want = cfg_model.debounce_ticks;
				REG_SETPOINT_MIN:    want = cfg_model.setpoint_min;
				REG_SETPOINT_MAX:    want = cfg_model.setpoint_max;
				default:             want = cfg_model.alarm_threshold;
			endcase
			if (rdata !== dsa_apb_data_t'(want))
				note_mismatch($sformatf("register %0d readback", i), 32'(want), rdata);
		end
	endtask

	// Let every pending result arrive before touching the registers.
	task automatic settle();
		tick_ch.valid <= 1'b0;
		while (pending_setpoints.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	// Offer one tick after a random gap and record its expected result.
	task automatic send_tick(input dsa_tick_t t, input bit typed,
			input setpoint_result_t want);
		int unsigned      gap;
		setpoint_result_t r;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid        <= 1'b1;
		tick_ch.up_key_raw   <= t.up_key_raw;
		tick_ch.down_key_raw <= t.down_key_raw;
		tick_ch.enc_a_edge   <= t.enc_a_edge;
		tick_ch.enc_a_level  <= t.enc_a_level;
		tick_ch.enc_b_level  <= t.enc_b_level;
		do @(posedge clk); while (!(tick_ch.valid && tick_ch.ready));
		r = advance_setpoint(t);
		pending_setpoints.push_back(typed ? want : r);
	endtask

	task automatic apply_phase_cfg(input dsa_val_t db, input dsa_val_t lo,
			input dsa_val_t hi, input dsa_val_t thr);
		settle();
		write_reg(REG_DEBOUNCE_TICKS, db);
		write_reg(REG_SETPOINT_MIN, lo);
		write_reg(REG_SETPOINT_MAX, hi);
		write_reg(REG_ALARM_THRESHOLD, thr);
		check_regs();
		hold_span = 2 * ((db > 40) ? 40 : int'(db)) + 4;
	endtask

	function automatic directed_row_t cfg_row(input dsa_reg_idx_t idx, input dsa_val_t val);
		directed_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.val = val;
		return row;
	endfunction

	function automatic directed_row_t tick_row(input logic [4:0] bits, input bit typed,
			input dsa_val_t sp, input logic al);
		directed_row_t row;
		row = '{default: '0};
		row.tick = dsa_tick_t'(bits);
		row.typed = typed;
		row.want.setpoint_value = sp;
		row.want.alarm = al;
		return row;
	endfunction

	// Result side: a random stall before each transfer is taken.
	initial begin
		int unsigned stall;
		result_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 5);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
		end
	end

	// Compare every result transfer with the oldest expectation.
	always @(posedge clk) begin : result_check
		setpoint_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_setpoints.size() == 0) begin
				note_mismatch("result with none pending, setpoint_value", '0,
					32'(result_ch.setpoint_value));
			end else begin
				want = pending_setpoints.pop_front();
				if (result_ch.setpoint_value !== want.setpoint_value)
					note_mismatch("setpoint_value", 32'(want.setpoint_value),
						32'(result_ch.setpoint_value));
				if (result_ch.alarm !== want.alarm)
					note_mismatch("alarm", 32'(want.alarm), 32'(result_ch.alarm));
			end
		end
	end

	// Stimulus: reset, directed table, then random phases.
	initial begin
		int unsigned random_ticks;
		int unsigned n_items;
		int          sp;
		int          lo;
		int          hi;
		int          thr;
		dsa_val_t    db;
		int unsigned sel;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_ch.valid = 1'b0;
		tick_ch.up_key_raw = 1'b1;
		tick_ch.down_key_raw = 1'b1;
		tick_ch.enc_a_edge = 1'b0;
		tick_ch.enc_a_level = 1'b1;
		tick_ch.enc_b_level = 1'b1;

		cfg_model.debounce_ticks = DEBOUNCE_TICKS_RST;
		cfg_model.setpoint_min = SETPOINT_MIN_RST;
		cfg_model.setpoint_max = SETPOINT_MAX_RST;
		cfg_model.alarm_threshold = ALARM_THRESHOLD_RST;
		setpoint_model = '0;
		for (int k = 0; k < 2; k++) begin
			key_last[k] = 1'b1;
			key_stable[k] = 1'b1;
			key_quiet[k] = '0;
			key_level[k] = 1'b1;
			key_hold[k] = 0;
		end

		// Tick bits are {up, down, A edge, A level, B level}; keys are low when pressed.
		directed_rows.push_back(tick_row(5'b11011, 1, 10'd0, 1'b0));
		directed_rows.push_back(tick_row(5'b11101, 1, 10'd1, 1'b0));
		directed_rows.push_back(tick_row(5'b11100, 1, 10'd0, 1'b0));
		directed_rows.push_back(tick_row(5'b11100, 1, 10'd0, 1'b0));
		directed_rows.push_back(tick_row(5'b11111, 1, 10'd0, 1'b0));
		directed_rows.push_back(tick_row(5'b11110, 1, 10'd0, 1'b0));
		directed_rows.push_back(tick_row(5'b11001, 1, 10'd0, 1'b0));
		directed_rows.push_back(tick_row(5'b01011, 1, 10'd0, 1'b0));
		// With no debounce a new key level is taken at once.
		directed_rows.push_back(cfg_row(REG_DEBOUNCE_TICKS, 10'd0));
		directed_rows.push_back(tick_row(5'b01011, 0, '0, 1'b0));
		directed_rows.push_back(tick_row(5'b01011, 0, '0, 1'b0));
		directed_rows.push_back(tick_row(5'b11011, 0, '0, 1'b0));
		directed_rows.push_back(tick_row(5'b10011, 0, '0, 1'b0));
		directed_rows.push_back(tick_row(5'b01101, 0, '0, 1'b0));
		directed_rows.push_back(tick_row(5'b10100, 0, '0, 1'b0));
		// Minimum above maximum: a step that falls below the minimum lands on it.
		directed_rows.push_back(cfg_row(REG_SETPOINT_MIN, 10'd1023));
		directed_rows.push_back(cfg_row(REG_SETPOINT_MAX, 10'd0));
		directed_rows.push_back(tick_row(5'b11101, 1, 10'd1023, 1'b1));
		directed_rows.push_back(tick_row(5'b11011, 1, 10'd1023, 1'b1));
		directed_rows.push_back(cfg_row(REG_ALARM_THRESHOLD, 10'd1023));
		directed_rows.push_back(tick_row(5'b11011, 1, 10'd1023, 1'b0));
		directed_rows.push_back(cfg_row(REG_SETPOINT_MIN, 10'd0));
		directed_rows.push_back(cfg_row(REG_SETPOINT_MAX, 10'd1023));
		directed_rows.push_back(tick_row(5'b11101, 1, 10'd1023, 1'b0));
		// Setpoint left outside a new range is held until the next step.
		directed_rows.push_back(cfg_row(REG_SETPOINT_MIN, 10'd100));
		directed_rows.push_back(cfg_row(REG_SETPOINT_MAX, 10'd200));
		directed_rows.push_back(tick_row(5'b11011, 1, 10'd1023, 1'b0));
		directed_rows.push_back(tick_row(5'b11111, 1, 10'd1023, 1'b0));
		directed_rows.push_back(tick_row(5'b11100, 0, '0, 1'b0));
		directed_rows.push_back(cfg_row(REG_ALARM_THRESHOLD, 10'd0));
		directed_rows.push_back(tick_row(5'b11011, 1, 10'd200, 1'b1));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_regs();

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				settle();
				write_reg(directed_rows[i].idx, directed_rows[i].val);
			end else begin
				send_tick(directed_rows[i].tick, directed_rows[i].typed,
					directed_rows[i].want);
			end
		end

		// Longest debounce with the up key held past the quiet-count ceiling.
		apply_phase_cfg(10'd1023, 10'd0, 10'd1023, 10'd512);
		steady = 1'b0;
		for (int i = 0; i < LONG_HOLD_TICKS; i++)
			send_tick(next_random_tick(1'b1), 1'b0, '0);
		random_ticks = LONG_HOLD_TICKS;

		while (random_ticks < RANDOM_TICKS) begin
			sel = $urandom_range(0, 9);
			if (sel < 6)
				db = dsa_val_t'($urandom_range(0, 6));
			else if (sel < 8)
				db = dsa_val_t'($urandom_range(7, 40));
			else if (sel == 8)
				db = 10'd0;
			else
				db = dsa_val_t'($urandom_range(41, 1023));

			sp = int'(setpoint_model);
			case ($urandom_range(0, 4))
				0: begin
					lo = 0;
					hi = 1023;
				end
				1: begin
					lo = $urandom_range(0, 511);
					hi = $urandom_range(512, 1023);
				end
				2: begin
					lo = $urandom_range(512, 1023);
					hi = $urandom_range(0, 511);
				end
				3: begin
					lo = $urandom_range(0, 1023);
					hi = lo;
				end
				default: begin
					lo = sp - int'($urandom_range(0, 8));
					hi = sp + int'($urandom_range(0, 8));
				end
			endcase
			if (lo < 0)
				lo = 0;
			if (hi > 1023)
				hi = 1023;

			if ($urandom_range(0, 3) == 0)
				thr = $urandom_range(0, 1) ? 1023 : 0;
			else
				thr = sp + int'($urandom_range(0, 10)) - 5;
			if (thr < 0)
				thr = 0;
			else if (thr > 1023)
				thr = 1023;

			apply_phase_cfg(db, dsa_val_t'(lo), dsa_val_t'(hi), dsa_val_t'(thr));
			steady = $urandom_range(0, 3) == 0;
			n_items = $urandom_range(60, 140);
			for (int i = 0; i < n_items; i++)
				send_tick(next_random_tick(1'b0), 1'b0, '0);
			random_ticks += n_items;
		end

		settle();
		if (mismatch_count == 0)
			$display("debounced_setpoint_adjuster_top: match");
		else
			$display("debounced_setpoint_adjuster_top: mismatch");
		$finish;
	end

endmodule
